// ----- design/visibility_partitioned_slot_list_assert.svh -----
// assertion macros for the visibility partitioned slot list
`ifndef VISIBILITY_PARTITIONED_SLOT_LIST_ASSERT_SVH
`define VISIBILITY_PARTITIONED_SLOT_LIST_ASSERT_SVH

`ifndef SYNTHESIS

`define VPSL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vpsl same-cycle check failed");

`define VPSL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vpsl next-cycle check failed");

`else

`define VPSL_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define VPSL_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/vpsl_pkg.sv -----
// shared constants, types and chain order function for the slot list
`timescale 1ns / 1ps

package vpsl_pkg;

    localparam int AXIS_BITS  = 5;
    localparam int SLOT_BITS  = 3 * AXIS_BITS;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int ADDR_BITS  = SLOT_BITS + 3;

    localparam logic [SLOT_BITS-1:0] SLOT_MASK = '1;

    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef logic [SLOT_BITS-1:0] t_slot;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_TAKEN,
        ST_A_LINK,
        ST_A_SELF,
        ST_A_PIVOT,
        ST_R_CHK,
        ST_R_UNLINK,
        ST_R_SELF,
        ST_R_PIVOT,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LATCH,
        OP_A_TAKEN,
        OP_A_LINK,
        OP_A_SELF,
        OP_A_PIVOT,
        OP_R_CHK,
        OP_R_UNLINK,
        OP_R_SELF,
        OP_R_PIVOT,
        OP_LOAD_OUT
    } t_op;

    typedef struct packed {
        logic init_last;
        logic mismatch;
    } t_sts;

    // de-interleave a chain position into {z, y, x}
    function automatic t_slot chain_slot(input t_slot pos);
        t_slot res;
        res = '0;
        for (int a = 0; a < AXIS_BITS; a++) begin
            res[a]                 = pos[3*a];
            res[AXIS_BITS + a]     = pos[3*a + 1];
            res[2*AXIS_BITS + a]   = pos[3*a + 2];
        end
        return res;
    endfunction

endpackage

// ----- design/vpsl_dp.sv -----
// datapath: link memories, mark memory, pivots and result registers
`timescale 1ns / 1ps

module vpsl_dp import vpsl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_op                  i_op,
    input  logic                 i_kind,
    input  logic [SLOT_BITS-1:0] i_slot_index,
    input  logic                 i_visible,
    output t_sts                 o_sts,
    output logic [ADDR_BITS-1:0] o_slot_address,
    output logic                 o_moved
);

    t_slot r_succ_mem [SLOT_COUNT];
    t_slot r_pred_mem [SLOT_COUNT];
    logic  r_mark_mem [SLOT_COUNT];

    t_slot r_succ_rd;
    t_slot r_pred_rd;
    logic  r_mark_rd;

    t_slot r_init_cnt;
    t_slot r_pivot_low;
    t_slot r_pivot_high;

    logic  r_kind;
    t_slot r_idx;
    logic  r_vis;
    t_slot r_taken;
    t_slot r_qp;
    t_slot r_qn;
    logic  r_was;

    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_moved;

    t_slot rd_addr;
    logic  succ_we;
    t_slot succ_wa;
    t_slot succ_wd;
    logic  pred_we;
    t_slot pred_wa;
    t_slot pred_wd;
    logic  mark_we;
    t_slot mark_wa;
    logic  mark_wd;

    always_comb begin
        rd_addr = (i_kind == KIND_REPORT) ? i_slot_index : '0;
        succ_we = 1'b0;
        succ_wa = r_idx;
        succ_wd = r_idx;
        pred_we = 1'b0;
        pred_wa = r_idx;
        pred_wd = r_idx;
        mark_we = 1'b0;
        mark_wa = r_idx;
        mark_wd = 1'b0;
        case (i_op)
            OP_INIT: begin
                succ_we = 1'b1;
                succ_wa = chain_slot(r_init_cnt);
                succ_wd = chain_slot(SLOT_BITS'(r_init_cnt + 1'b1));
                pred_we = 1'b1;
                pred_wa = chain_slot(r_init_cnt);
                pred_wd = chain_slot(SLOT_BITS'(r_init_cnt - 1'b1));
                mark_we = 1'b1;
                mark_wa = chain_slot(r_init_cnt);
                mark_wd = (r_init_cnt == '0);
            end
            OP_A_TAKEN: begin
                rd_addr = r_succ_rd;
            end
            OP_A_LINK: begin
                succ_we = 1'b1;
                succ_wa = '0;
                succ_wd = r_succ_rd;
                pred_we = 1'b1;
                pred_wa = r_succ_rd;
                pred_wd = '0;
                mark_we = 1'b1;
                mark_wa = r_taken;
                mark_wd = 1'b1;
            end
            OP_A_SELF: begin
                succ_we = 1'b1;
                succ_wa = r_taken;
                succ_wd = r_pivot_high;
                pred_we = 1'b1;
                pred_wa = r_taken;
                pred_wd = r_pivot_low;
            end
            OP_A_PIVOT: begin
                succ_we = 1'b1;
                succ_wa = r_pivot_low;
                succ_wd = r_taken;
                pred_we = 1'b1;
                pred_wa = r_pivot_high;
                pred_wd = r_taken;
            end
            OP_R_UNLINK: begin
                succ_we = 1'b1;
                succ_wa = r_qp;
                succ_wd = r_qn;
                pred_we = 1'b1;
                pred_wa = r_qn;
                pred_wd = r_qp;
            end
            OP_R_SELF: begin
                succ_we = 1'b1;
                succ_wa = r_idx;
                succ_wd = r_pivot_high;
                pred_we = 1'b1;
                pred_wa = r_idx;
                pred_wd = r_pivot_low;
                mark_we = 1'b1;
                mark_wa = r_idx;
                mark_wd = ~r_was;
            end
            OP_R_PIVOT: begin
                succ_we = 1'b1;
                succ_wa = r_pivot_low;
                succ_wd = r_idx;
                pred_we = 1'b1;
                pred_wa = r_pivot_high;
                pred_wd = r_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (succ_we) begin
            r_succ_mem[succ_wa] <= succ_wd;
        end
        r_succ_rd <= r_succ_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pred_we) begin
            r_pred_mem[pred_wa] <= pred_wd;
        end
        r_pred_rd <= r_pred_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[mark_wa] <= mark_wd;
        end
        r_mark_rd <= r_mark_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt   <= '0;
            r_pivot_low  <= SLOT_MASK;
            r_pivot_high <= '0;
        end else begin
            if (i_op == OP_INIT) begin
                r_init_cnt <= SLOT_BITS'(r_init_cnt + 1'b1);
            end
            if (i_op == OP_A_PIVOT) begin
                r_pivot_high <= r_taken;
            end
            if (i_op == OP_R_PIVOT) begin
                if (r_was) begin
                    r_pivot_low <= r_idx;
                end else begin
                    r_pivot_high <= r_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LATCH: begin
                r_kind <= i_kind;
                r_idx  <= i_slot_index;
                r_vis  <= i_visible;
            end
            OP_A_TAKEN: begin
                r_taken <= r_succ_rd;
            end
            OP_R_CHK: begin
                r_qp  <= r_pred_rd;
                r_qn  <= r_succ_rd;
                r_was <= r_mark_rd;
            end
            OP_LOAD_OUT: begin
                r_addr  <= (r_kind == KIND_REPORT) ? '0 : {r_taken, 3'b000};
                r_moved <= (r_kind == KIND_REPORT) && (r_was != r_vis);
            end
            default: begin
            end
        endcase
    end

    assign o_sts.init_last = (r_init_cnt == SLOT_MASK);
    assign o_sts.mismatch  = (r_mark_rd != r_vis);
    assign o_slot_address  = r_addr;
    assign o_moved         = r_moved;

endmodule

// ----- design/vpsl_ctrl.sv -----
// controller: init walk, item sequencing and output word handshake
`timescale 1ns / 1ps

module vpsl_ctrl import vpsl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_kind,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_op  o_op,
    output logic o_ready,
    output logic o_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_sts.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_kind == KIND_REPORT) ? ST_R_CHK : ST_A_TAKEN;
                end
            end
            ST_A_TAKEN:  n_state = ST_A_LINK;
            ST_A_LINK:   n_state = ST_A_SELF;
            ST_A_SELF:   n_state = ST_A_PIVOT;
            ST_A_PIVOT:  n_state = ST_DONE;
            ST_R_CHK: begin
                n_state = i_sts.mismatch ? ST_R_UNLINK : ST_DONE;
            end
            ST_R_UNLINK: n_state = ST_R_SELF;
            ST_R_SELF:   n_state = ST_R_PIVOT;
            ST_R_PIVOT:  n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_op = OP_NONE;
        case (r_state)
            ST_INIT:     o_op = OP_INIT;
            ST_IDLE:     o_op = i_valid ? OP_LATCH : OP_NONE;
            ST_A_TAKEN:  o_op = OP_A_TAKEN;
            ST_A_LINK:   o_op = OP_A_LINK;
            ST_A_SELF:   o_op = OP_A_SELF;
            ST_A_PIVOT:  o_op = OP_A_PIVOT;
            ST_R_CHK:    o_op = OP_R_CHK;
            ST_R_UNLINK: o_op = OP_R_UNLINK;
            ST_R_SELF:   o_op = OP_R_SELF;
            ST_R_PIVOT:  o_op = OP_R_PIVOT;
            ST_DONE:     o_op = out_free ? OP_LOAD_OUT : OP_NONE;
            default:     o_op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_op == OP_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- design/visibility_partitioned_slot_list.sv -----
// Slot list with a visibility partition, 32768 slots held in a circular doubly
// linked list kept in three memories (successor, predecessor, mark), each with one
// write port and one registered read port.
// After reset an initialization walk writes one chain entry per cycle, during
// which no input word is accepted. An allocate word passes the taken, link,
// self and pivot states and a report word that flips the mark the check, unlink,
// self and pivot states before its result is registered in the done state (a
// report that leaves the mark unchanged goes from check to done); the steps are
// set by the serial link reads and writes through the memory write ports. The
// result sits in an output register so the next word can be taken while it waits.
`timescale 1ns / 1ps

`include "visibility_partitioned_slot_list_assert.svh"

module visibility_partitioned_slot_list import vpsl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [SLOT_BITS-1:0] i_slot_index,
    input  logic                 i_visible,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ADDR_BITS-1:0] o_slot_address,
    output logic                 o_moved
);

    t_op  op;
    t_sts sts;

    vpsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_op        (op),
        .o_ready     (o_ready),
        .o_valid     (o_valid)
    );

    vpsl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_kind         (i_kind),
        .i_slot_index   (i_slot_index),
        .i_visible      (i_visible),
        .o_sts          (sts),
        .o_slot_address (o_slot_address),
        .o_moved        (o_moved)
    );

    `VPSL_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `VPSL_ASSERT_IMP(a_no_accept_in_init, i_clk, i_rst_n, op == OP_INIT, !o_ready)
    `VPSL_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, op == OP_LOAD_OUT, !o_valid || i_ready)

endmodule

// ----- tb/sv/visibility_partitioned_slot_list_tb.sv -----
// testbench for the visibility partitioned slot list: directed table, random words, list predictor
`timescale 1ns / 1ps

module visibility_partitioned_slot_list_tb import vpsl_pkg::*; ();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_WORDS   = 308;
    localparam int NUM_DIRECTED  = 21;
    localparam int RECENT_DEPTH  = 16;
    localparam int MAX_REPORTED  = 10;

    typedef struct packed {
        logic                 kind;
        t_slot                slot;
        logic                 vis;
        logic                 typed;
        logic [ADDR_BITS-1:0] addr;
        logic                 moved;
    } t_stim_row;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic                 moved;
    } t_slot_result;

    // expected result typed in only where obvious
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{KIND_ALLOC,  15'd0,     1'b0, 1'b1, 18'd8,    1'b0},
        '{KIND_ALLOC,  15'd32767, 1'b1, 1'b1, 18'd256,  1'b0},
        '{KIND_ALLOC,  15'd0,     1'b1, 1'b1, 18'd264,  1'b0},
        '{KIND_ALLOC,  15'd21845, 1'b0, 1'b1, 18'd8192, 1'b0},
        '{KIND_REPORT, 15'd0,     1'b1, 1'b1, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd32767, 1'b0, 1'b1, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd5,     1'b0, 1'b1, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd1024,  1'b1, 1'b1, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd1024,  1'b0, 1'b0, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd32767, 1'b1, 1'b0, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd32,    1'b0, 1'b0, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd0,     1'b0, 1'b0, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd2,     1'b1, 1'b0, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd3,     1'b1, 1'b0, 18'd0,    1'b0},
        '{KIND_ALLOC,  15'd10922, 1'b1, 1'b0, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd16384, 1'b1, 1'b0, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd16383, 1'b1, 1'b0, 18'd0,    1'b0},
        '{KIND_ALLOC,  15'd0,     1'b0, 1'b0, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd1,     1'b0, 1'b0, 18'd0,    1'b0},
        '{KIND_REPORT, 15'd1,     1'b1, 1'b0, 18'd0,    1'b0},
        '{KIND_ALLOC,  15'd32767, 1'b1, 1'b0, 18'd0,    1'b0}
    };

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 i_kind       = 1'b0;
    logic [SLOT_BITS-1:0] i_slot_index = '0;
    logic                 i_visible    = 1'b0;
    logic                 i_ready      = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [ADDR_BITS-1:0] o_slot_address;
    logic                 o_moved;

    // list predictor state
    t_slot succ_link [SLOT_COUNT];
    t_slot pred_link [SLOT_COUNT];
    bit    mark_bit  [SLOT_COUNT];
    t_slot pivot_lo;
    t_slot pivot_hi;
    t_slot recent_slots[$];

    t_slot_result pending_results[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic hold_req      = 1'b0;
    bit  hold_done      = 1'b0;
    int  hold_left      = 0;
    int  err_cnt        = 0;
    int  cycle_cnt      = 0;
    int  alloc_cnt      = 0;
    int  moved_cnt      = 0;
    int  kept_cnt       = 0;
    int  pivot_touch_cnt = 0;

    visibility_partitioned_slot_list u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_slot_index   (i_slot_index),
        .i_visible      (i_visible),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_slot_address (o_slot_address),
        .o_moved        (o_moved)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // chain position to slot: bit b of the position goes to axis b%3, lane b/3
    function automatic t_slot morton_slot(input int unsigned pos);
        t_slot p;
        t_slot r;
        p = t_slot'(pos);
        r = '0;
        for (int b = 0; b < SLOT_BITS; b++) begin
            r[(b % 3) * AXIS_BITS + b / 3] = p[b];
        end
        return r;
    endfunction

    task automatic init_slot_list();
        t_slot s;
        for (int unsigned p = 0; p < SLOT_COUNT; p++) begin
            s = morton_slot(p);
            succ_link[s] = morton_slot(p + 1);
            pred_link[s] = morton_slot(p + SLOT_COUNT - 1);
            mark_bit[s]  = 1'b0;
        end
        mark_bit[0] = 1'b1;
        pivot_lo    = '1;
        pivot_hi    = '0;
    endtask

    task automatic note_recent(input t_slot s);
        recent_slots.push_back(s);
        if (recent_slots.size() > RECENT_DEPTH) begin
            void'(recent_slots.pop_front());
        end
    endtask

    task automatic apply_word_to_list(input logic kind, input t_slot idx, input logic vis,
                                      output t_slot_result res);
        t_slot taken;
        t_slot after;
        t_slot qp;
        t_slot qn;
        bit    was;
        res = '0;
        if (kind == KIND_ALLOC) begin
            taken            = succ_link[0];
            succ_link[0]     = succ_link[taken];
            after            = succ_link[taken];
            pred_link[after] = '0;
            pred_link[taken] = pivot_lo;
            succ_link[taken] = pivot_hi;
            mark_bit[taken]  = 1'b1;
            succ_link[pivot_lo] = taken;
            pred_link[pivot_hi] = taken;
            pivot_hi  = taken;
            res.addr  = {taken, 3'b000};
            alloc_cnt++;
            note_recent(taken);
        end else begin
            was = mark_bit[idx];
            if (was != vis) begin
                qp = pred_link[idx];
                qn = succ_link[idx];
                if (idx == pivot_lo || idx == pivot_hi || qp == pivot_lo || qp == pivot_hi ||
                    qn == pivot_lo || qn == pivot_hi) begin
                    pivot_touch_cnt++;
                end
                succ_link[qp]  = qn;
                pred_link[qn]  = qp;
                pred_link[idx] = pivot_lo;
                succ_link[idx] = pivot_hi;
                mark_bit[idx]  = ~was;
                succ_link[pivot_lo] = idx;
                pred_link[pivot_hi] = idx;
                if (was) begin
                    pivot_lo = idx;
                end else begin
                    pivot_hi = idx;
                end
                res.moved = 1'b1;
                moved_cnt++;
                note_recent(idx);
            end else begin
                kept_cnt++;
            end
        end
    endtask

    // drive one word, wait for acceptance, then update the predictor
    task automatic send_word(input logic kind, input t_slot slot, input logic vis,
                             input logic typed, input logic [ADDR_BITS-1:0] taddr,
                             input logic tmoved);
        t_slot_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_slot_index <= slot;
        i_visible    <= vis;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        apply_word_to_list(kind, slot, vis, res);
        if (typed) begin
            res.addr  = taddr;
            res.moved = tmoved;
        end
        pending_results.push_back(res);
    endtask

    // aim reports at pivots, their neighbours, the slot after slot 0 and recently touched slots, besides random ones
    function automatic t_slot pick_report_slot();
        t_slot s;
        case ($urandom_range(0, 13))
            0, 1, 2: s = t_slot'($urandom_range(0, SLOT_COUNT - 1));
            3:       s = t_slot'($urandom_range(0, 63));
            4:       s = pivot_lo;
            5:       s = pivot_hi;
            6:       s = succ_link[pivot_lo];
            7:       s = pred_link[pivot_hi];
            8:       s = pred_link[pivot_lo];
            9:       s = succ_link[pivot_hi];
            10:      s = succ_link[0];
            default: begin
                if (recent_slots.size() != 0) begin
                    s = recent_slots[$urandom_range(0, recent_slots.size() - 1)];
                end else begin
                    s = t_slot'($urandom);
                end
            end
        endcase
        return s;
    endfunction

    task automatic send_random_word();
        logic  kind;
        t_slot slot;
        logic  vis;
        if ($urandom_range(0, 99) < 35) begin
            kind = KIND_ALLOC;
            slot = t_slot'($urandom);
            vis  = 1'($urandom);
        end else begin
            kind = KIND_REPORT;
            slot = pick_report_slot();
            if ($urandom_range(0, 99) < 75) begin
                vis = ~mark_bit[slot];
            end else begin
                vis = mark_bit[slot];
            end
        end
        send_word(kind, slot, vis, 1'b0, '0, 1'b0);
    endtask

    task automatic flag_error(input string what, input t_slot_result want);
        err_cnt++;
        if (err_cnt <= MAX_REPORTED) begin
            $display("%s at cycle %0d: expected addr %0h moved %0b, got addr %0h moved %0b",
                     what, cycle_cnt, want.addr, want.moved, o_slot_address, o_moved);
        end
    endtask

    // result checker and receiver ready
    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                flag_error("unexpected word", '0);
            end else begin
                want = pending_results.pop_front();
                if (o_slot_address !== want.addr || o_moved !== want.moved) begin
                    flag_error("mismatch", want);
                end
            end
        end
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        init_slot_list();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_word(directed_rows[r].kind, directed_rows[r].slot, directed_rows[r].vis,
                      directed_rows[r].typed, directed_rows[r].addr, directed_rows[r].moved);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_req      <= 1'b1;
                end
                1: begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default: begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_random_word();
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d allocates, %0d relinking reports, %0d reports with no change",
                 alloc_cnt, moved_cnt, kept_cnt);
        $display("%0d relinks touched a pivot or its neighbour; %0d errors seen",
                 pivot_touch_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/vpsl_pkg.sv
design/vpsl_dp.sv
design/vpsl_ctrl.sv
design/visibility_partitioned_slot_list.sv
tb/sv/visibility_partitioned_slot_list_tb.sv
